// ===== hdl/lsrw_pkg.sv =====
package lsrw_pkg;

    localparam int MaxOrder = 16;
    localparam int IdxW     = 4;
    localparam int AddrW    = 3 * IdxW;
    localparam int CubeDepth = MaxOrder * MaxOrder * MaxOrder;

    localparam logic [1:0] OP_MOVE    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] ST_MOVED   = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;
    localparam logic [1:0] ST_RESTART = 2'd3;

    localparam logic [1:0] CELL_ZERO = 2'b00;
    localparam logic [1:0] CELL_ONE  = 2'b01;
    localparam logic [1:0] CELL_NEG  = 2'b11;

    localparam logic [1:0] AX_L = 2'd0;
    localparam logic [1:0] AX_C = 2'd1;
    localparam logic [1:0] AX_R = 2'd2;

    localparam logic [2:0] WS_Z   = 3'd0;
    localparam logic [2:0] WS_L   = 3'd1;
    localparam logic [2:0] WS_C   = 3'd2;
    localparam logic [2:0] WS_R   = 3'd3;
    localparam logic [2:0] WS_CL  = 3'd4;
    localparam logic [2:0] WS_RL  = 3'd5;
    localparam logic [2:0] WS_RC  = 3'd6;
    localparam logic [2:0] WS_OPP = 3'd7;

    localparam logic [4:0] CFG_SIZE_RESET = 5'd16;

    typedef struct packed {
        logic       load;
        logic       clr_start;
        logic       clr_en;
        logic       rd_en;
        logic       rd_focus;
        logic       rd_opp;
        logic       scan_start;
        logic       scan_en;
        logic [1:0] axis;
        logic       wr_en;
        logic [2:0] wsel;
        logic       fin_move;
        logic       restart_state;
    } lsrw_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       scan_last;
        logic       cand_ok;
        logic       found_all;
        logic       improper;
        logic [1:0] op;
    } lsrw_stat_t;

endpackage

// ===== hdl/lsrw_datapath.sv =====
module lsrw_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [4:0]             order,
    input  logic [16:0]            in_data,
    input  lsrw_pkg::lsrw_cmd_t    cmd,
    output lsrw_pkg::lsrw_stat_t   stat,
    output logic                   proper,
    output logic [3:0]             letter_out
);

    logic [1:0] cube_mem [lsrw_pkg::CubeDepth];
    logic [1:0] rd_data_reg;

    logic [1:0] op_reg;
    logic [3:0] r_reg, c_reg, l_reg;
    logic       ps_reg, pc_reg, pr_reg;
    logic       improper_reg;
    logic [3:0] nr_reg, nc_reg, nl_reg;

    logic [3:0] zr, zc, zl;
    logic [4:0] k_reg, k_next;
    logic [4:0] kd_reg;
    logic [1:0] axd_reg;
    logic       scan_d_reg;
    logic [3:0] w_reg [3];
    logic       f_reg [3];
    logic       take_reg;
    logic [3:0] letter_reg;
    logic       opp_one_reg;
    logic       opp_pend_reg;

    logic [11:0] clr_reg;
    logic [4:0]  cr_sum;
    logic [3:0]  cr_l;
    logic        clr_done_reg;

    logic [11:0] rd_addr, wr_addr;
    logic [1:0]  wr_val;
    logic        wr_go;
    logic [3:0]  r3, c2, l1;

    assign zr = (improper_reg && op_reg != lsrw_pkg::OP_READ) ? nr_reg : r_reg;
    assign zc = (improper_reg && op_reg != lsrw_pkg::OP_READ) ? nc_reg : c_reg;
    assign zl = improper_reg ? nl_reg : l_reg;
    assign r3 = w_reg[2];
    assign c2 = w_reg[1];
    assign l1 = w_reg[0];

    always_comb
    begin
        k_next = k_reg + 5'd1;
        if (cmd.rd_opp)
            rd_addr = {r3, c2, l1};
        else if (cmd.rd_focus)
            rd_addr = {zr, zc, zl};
        else
        begin
            case (cmd.axis)
                lsrw_pkg::AX_L: rd_addr = {zr, zc, k_reg[3:0]};
                lsrw_pkg::AX_C: rd_addr = {zr, k_reg[3:0], zl};
                default:        rd_addr = {k_reg[3:0], zc, zl};
            endcase
        end
    end

    // restart sweep: each cycle one cell, value from cyclic rule
    always_comb
    begin
        cr_sum = {1'b0, clr_reg[11:8]} + {1'b0, clr_reg[7:4]};
        cr_l   = (cr_sum >= order) ? 4'(cr_sum - order) : cr_sum[3:0];
    end

    always_comb
    begin
        wr_go   = 1'b0;
        wr_addr = {zr, zc, zl};
        wr_val  = lsrw_pkg::CELL_ZERO;
        if (cmd.clr_en)
        begin
            wr_go   = 1'b1;
            wr_addr = clr_reg;
            wr_val  = ({1'b0, clr_reg[11:8]} < order && {1'b0, clr_reg[7:4]} < order
                       && clr_reg[3:0] == cr_l) ? lsrw_pkg::CELL_ONE : lsrw_pkg::CELL_ZERO;
        end
        else if (cmd.wr_en)
        begin
            wr_go = 1'b1;
            case (cmd.wsel)
                lsrw_pkg::WS_Z:
                begin
                    wr_addr = {zr, zc, zl};
                    wr_val  = improper_reg ? lsrw_pkg::CELL_ZERO : lsrw_pkg::CELL_ONE;
                end
                lsrw_pkg::WS_L:  wr_addr = {zr, zc, l1};
                lsrw_pkg::WS_C:  wr_addr = {zr, c2, zl};
                lsrw_pkg::WS_R:  wr_addr = {r3, zc, zl};
                lsrw_pkg::WS_CL:
                begin
                    wr_addr = {zr, c2, l1};
                    wr_val  = lsrw_pkg::CELL_ONE;
                end
                lsrw_pkg::WS_RL:
                begin
                    wr_addr = {r3, zc, l1};
                    wr_val  = lsrw_pkg::CELL_ONE;
                end
                lsrw_pkg::WS_RC:
                begin
                    wr_addr = {r3, c2, zl};
                    wr_val  = lsrw_pkg::CELL_ONE;
                end
                default:
                begin
                    wr_addr = {r3, c2, l1};
                    wr_val  = opp_one_reg ? lsrw_pkg::CELL_ZERO : lsrw_pkg::CELL_NEG;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
            cube_mem[wr_addr] <= wr_val;
        if (cmd.rd_en)
            rd_data_reg <= cube_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_data[1:0];
            r_reg  <= in_data[5:2];
            c_reg  <= in_data[9:6];
            l_reg  <= in_data[13:10];
            ps_reg <= in_data[14];
            pc_reg <= in_data[15];
            pr_reg <= in_data[16];
        end
        if (opp_pend_reg)
            opp_one_reg <= (rd_data_reg == lsrw_pkg::CELL_ONE);
    end

    // scan: reads issued with k, results arrive in the following cycle with kd
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            kd_reg       <= '0;
            axd_reg      <= '0;
            scan_d_reg   <= 1'b0;
            take_reg     <= 1'b0;
            f_reg[0]     <= 1'b0;
            f_reg[1]     <= 1'b0;
            f_reg[2]     <= 1'b0;
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
            improper_reg <= 1'b0;
            nr_reg       <= '0;
            nc_reg       <= '0;
            nl_reg       <= '0;
            letter_reg   <= '0;
        end
        else
        begin
            scan_d_reg <= cmd.scan_en;
            kd_reg     <= k_reg;
            axd_reg    <= cmd.axis;
            if (cmd.scan_start)
                k_reg <= '0;
            else if (cmd.scan_en)
                k_reg <= k_next;
            if (cmd.load)
            begin
                f_reg[0]   <= 1'b0;
                f_reg[1]   <= 1'b0;
                f_reg[2]   <= 1'b0;
                letter_reg <= '0;
            end
            if (cmd.scan_start)
            begin
                case (cmd.axis)
                    lsrw_pkg::AX_L: take_reg <= ps_reg;
                    lsrw_pkg::AX_C: take_reg <= pc_reg;
                    default:        take_reg <= pr_reg;
                endcase
            end
            if (scan_d_reg)
            begin
                if (op_reg == lsrw_pkg::OP_READ)
                begin
                    if (rd_data_reg != lsrw_pkg::CELL_ZERO)
                        letter_reg <= kd_reg[3:0];
                end
                else if (rd_data_reg == lsrw_pkg::CELL_ONE)
                begin
                    if (!improper_reg || take_reg)
                    begin
                        w_reg[axd_reg] <= kd_reg[3:0];
                        f_reg[axd_reg] <= 1'b1;
                        if (!cmd.scan_start)
                            take_reg <= 1'b0;
                    end
                    else if (!cmd.scan_start)
                        take_reg <= 1'b1;
                end
            end
            if (cmd.clr_start)
            begin
                clr_reg      <= '0;
                clr_done_reg <= 1'b0;
            end
            else if (cmd.clr_en)
            begin
                clr_reg <= clr_reg + 12'd1;
                if (clr_reg == 12'hFFF)
                    clr_done_reg <= 1'b1;
            end
            if (cmd.restart_state)
            begin
                improper_reg <= 1'b0;
                nr_reg       <= '0;
                nc_reg       <= '0;
                nl_reg       <= '0;
            end
            else if (cmd.fin_move)
            begin
                if (opp_one_reg)
                    improper_reg <= 1'b0;
                else
                begin
                    improper_reg <= 1'b1;
                    nr_reg       <= r3;
                    nc_reg       <= c2;
                    nl_reg       <= l1;
                end
            end
        end
    end

    // capture opposite-corner value the cycle after its read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            opp_pend_reg <= 1'b0;
        else
            opp_pend_reg <= cmd.rd_opp;
    end

    logic range_ok;
    always_comb
    begin
        if (op_reg == lsrw_pkg::OP_READ)
            range_ok = {1'b0, r_reg} < order && {1'b0, c_reg} < order;
        else
            range_ok = {1'b0, zr} < order && {1'b0, zc} < order && {1'b0, zl} < order;
    end

    assign stat.clr_done  = clr_done_reg;
    assign stat.scan_last = (k_next == order);
    assign stat.cand_ok   = range_ok && (op_reg == lsrw_pkg::OP_READ || improper_reg
                                         || rd_data_reg == lsrw_pkg::CELL_ZERO);
    assign stat.found_all = f_reg[0] && f_reg[1] && f_reg[2];
    assign stat.improper  = improper_reg;
    assign stat.op        = op_reg;
    assign proper         = !improper_reg;
    assign letter_out     = (op_reg == lsrw_pkg::OP_READ) ? letter_reg : 4'd0;

endmodule

// ===== hdl/lsrw_ctrl.sv =====
module lsrw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output lsrw_pkg::lsrw_cmd_t   cmd,
    input  lsrw_pkg::lsrw_stat_t  stat
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_OPPRD = 4'd6;
    localparam logic [3:0] S_OPPW  = 4'd7;
    localparam logic [3:0] S_WR    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_FOC   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [2:0] ws_reg, ws_next;
    logic [1:0] status_reg, status_next;

    always_comb
    begin
        cmd         = '0;
        cmd.axis    = axis_reg;
        cmd.wsel    = ws_reg;
        state_next  = state_reg;
        axis_next   = axis_reg;
        ws_next     = ws_reg;
        status_next = status_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_done)
                    state_next = (status_reg == lsrw_pkg::ST_RESTART) ? S_OUT : S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                axis_next = lsrw_pkg::AX_L;
                unique case (stat.op)
                    lsrw_pkg::OP_MOVE:
                    begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_focus = 1'b1;
                        state_next   = S_FOC;
                    end
                    lsrw_pkg::OP_READ:
                    begin
                        status_next = lsrw_pkg::ST_READ;
                        state_next  = S_CHK;
                    end
                    lsrw_pkg::OP_RESTART:
                    begin
                        status_next   = lsrw_pkg::ST_RESTART;
                        cmd.clr_start = 1'b1;
                        cmd.restart_state = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    default:
                    begin
                        status_next = lsrw_pkg::ST_REJECT;
                        state_next  = S_OUT;
                    end
                endcase
            end
            S_FOC:
                state_next = S_CHK;
            S_CHK:
            begin
                if (!stat.cand_ok && stat.op == lsrw_pkg::OP_MOVE)
                begin
                    status_next = lsrw_pkg::ST_REJECT;
                    state_next  = S_OUT;
                end
                else if (stat.op == lsrw_pkg::OP_READ && !stat.cand_ok)
                    state_next = S_OUT;
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                cmd.rd_en   = 1'b1;
                if (stat.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (stat.op == lsrw_pkg::OP_READ)
                    state_next = S_OUT;
                else if (axis_reg != lsrw_pkg::AX_R)
                begin
                    axis_next  = axis_reg + 2'd1;
                    cmd.axis   = axis_reg + 2'd1;
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!stat.found_all)
                begin
                    status_next = lsrw_pkg::ST_REJECT;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_opp = 1'b1;
                    state_next = S_OPPRD;
                end
            end
            S_OPPRD:
                state_next = S_OPPW;
            S_OPPW:
            begin
                ws_next    = lsrw_pkg::WS_Z;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr_en = 1'b1;
                ws_next   = ws_reg + 3'd1;
                if (ws_reg == lsrw_pkg::WS_OPP)
                begin
                    cmd.fin_move = 1'b1;
                    status_next  = lsrw_pkg::ST_MOVED;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            axis_reg   <= '0;
            ws_reg     <= '0;
            status_reg <= lsrw_pkg::ST_MOVED;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            ws_reg     <= ws_next;
            status_reg <= status_next;
        end
    end

    assign status = status_reg;

endmodule

// ===== hdl/latin_square_random_walk.sv =====
// Jacobson-Matthews walk on a 16x16x16 incidence cube held in a 4096-entry
// two-bit memory. After reset, and after each restart beat, a clearing pass
// writes the cyclic square one cell a cycle with no input taken. A full move
// makes three line scans of one memory read a cycle and eight single writes;
// a read makes one line scan. One beat is handled at a time and each input
// beat gives one output beat.
module latin_square_random_walk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], row[5:2], column[9:6], symbol[13:10], pick_symbol[14],
    // pick_column[15], pick_row[16], zero fill
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], proper[2], letter_out[6:3], zero fill
    output logic [7:0]  m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lsrw_pkg::lsrw_cmd_t  cmd;
    lsrw_pkg::lsrw_stat_t stat;
    logic [4:0] size_reg;
    logic [4:0] order;
    logic [1:0] status;
    logic       proper;
    logic [3:0] letter_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= lsrw_pkg::CFG_SIZE_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0)
            size_reg <= pwdata[4:0];
    end

    assign order  = (size_reg < 5'd2) ? 5'd2 :
                    (size_reg > 5'(lsrw_pkg::MaxOrder)) ? 5'(lsrw_pkg::MaxOrder) : size_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {27'd0, size_reg} : 32'd0;

    lsrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd),
        .stat      (stat)
    );

    lsrw_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .order      (order),
        .in_data    (s_axis_tdata[16:0]),
        .cmd        (cmd),
        .stat       (stat),
        .proper     (proper),
        .letter_out (letter_out)
    );

    assign m_axis_tdata = {1'b0, letter_out, proper, status};

endmodule
